@@ rtl/lbp_pkg.sv @@
package lbp_pkg;

  // APB register map, byte addresses
  localparam logic [2:0] REG_ADDR_WIDTH  = 3'd0;
  localparam logic [2:0] REG_ADDR_HEIGHT = 3'd4;

  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [15:0] HEIGHT_RESET = 16'd480;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_LW    = 3;

  // complete 3x3 neighborhood of one interior pixel
  typedef struct packed {
    logic [7:0] tl;
    logic [7:0] t;
    logic [7:0] tr;
    logic [7:0] r;
    logic [7:0] br;
    logic [7:0] b;
    logic [7:0] bl;
    logic [7:0] l;
    logic [7:0] ctr;
    logic       last;
  } lbp_win_t;

  typedef struct packed {
    logic            empty;
    logic [Q_LW-1:0] level;
  } lbp_qstat_t;

endpackage

@@ rtl/lbp_3x3_pattern_stream.sv @@
// channel   dir  handshake            payload
// in_       in   in_tvalid/in_tready  tdata[7:0] pixel
// out_      out  out_tvalid/tready    tdata[7:0] code, tlast = last interior code
// cfg_      in   APB, pready = 1      0x0 frame_width[10:0], 0x4 frame_height[15:0]
//
// One pixel word per cycle sustained unless the queue backs up; out_tvalid follows the
// pixel completing a window through line buffer read reg, queue and output reg.
// Line buffers are single-write RAMs read on accept and written in the cycle after.
// rst_n clears counters, window and queue; line buffer contents are not cleared.
// in_tready drops only when the 4-entry queue plus the in-flight word fill it.
module lbp_3x3_pattern_stream #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] pixel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] code
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [10:0] width_r;
  logic [15:0] height_r;
  logic        cfg_wr;

  lbp_pkg::lbp_qstat_t q_stat;
  lbp_pkg::lbp_win_t   push_word, pop_word;
  logic                push, pop;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= lbp_pkg::WIDTH_RESET;
      height_r <= lbp_pkg::HEIGHT_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == lbp_pkg::REG_ADDR_HEIGHT[2]) begin
        height_r <= cfg_pwdata[15:0];
      end else begin
        width_r <= cfg_pwdata[10:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == lbp_pkg::REG_ADDR_HEIGHT[2]) ?
                      {16'd0, height_r} : {21'd0, width_r};

  lbp_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_pixel     (in_tdata),
    .in_ready     (in_tready),
    .frame_width  (width_r),
    .frame_height (height_r),
    .q_stat       (q_stat),
    .push         (push),
    .push_word    (push_word)
  );

  lbp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .pop_word  (pop_word),
    .stat      (q_stat)
  );

  lbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_word    (pop_word),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_code  (out_tdata),
    .out_last  (out_tlast)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> q_stat.level != lbp_pkg::Q_LW'(lbp_pkg::Q_DEPTH))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("queue underflow");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && q_stat.empty)
    else $error("output or queue busy after reset");

endmodule

@@ rtl/lbp_front.sv @@
module lbp_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [7:0]          in_pixel,
  output logic                in_ready,
  input  logic [10:0]         frame_width,
  input  logic [15:0]         frame_height,
  input  lbp_pkg::lbp_qstat_t q_stat,
  output logic                push,
  output lbp_pkg::lbp_win_t   push_word
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [7:0] upper_mem [MAX_WIDTH];
  logic [7:0] middle_mem [MAX_WIDTH];

  logic [CW-1:0] col_r, col_nxt;
  logic [15:0]   row_r, row_nxt;
  logic [CW-1:0] wm1;
  logic [15:0]   hm1;
  logic          accept, row_end, frame_end, emit;

  logic          b_valid_r;
  logic          b_emit_r;
  logic          b_last_r;
  logic [7:0]    b_pix_r;
  logic [CW-1:0] b_idx_r;
  logic [7:0]    top_rd_r;
  logic [7:0]    mid_rd_r;
  logic [7:0]    win_r [6];

  assign in_ready = (q_stat.level + lbp_pkg::Q_LW'(b_valid_r)) <
                    lbp_pkg::Q_LW'(lbp_pkg::Q_DEPTH);
  assign accept   = in_valid & in_ready;

  always_comb begin
    if (frame_width < 11'd3) begin
      wm1 = CW'(2);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      wm1 = CW'(MAX_WIDTH - 1);
    end else begin
      wm1 = CW'(frame_width - 11'd1);
    end
    hm1 = (frame_height < 16'd3) ? 16'd2 : frame_height - 16'd1;
  end

  assign row_end   = col_r >= wm1;
  assign frame_end = row_end && (row_r >= hm1);
  assign emit      = (row_r >= 16'd2) && (col_r >= CW'(2));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? 16'd0 : row_r + 16'd1;
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      b_valid_r <= 1'b0;
      b_emit_r  <= 1'b0;
      b_last_r  <= 1'b0;
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      b_valid_r <= accept;
      if (accept) begin
        b_emit_r <= emit;
        b_last_r <= frame_end;
      end
      if (b_valid_r) begin
        win_r[0] <= win_r[1];
        win_r[1] <= top_rd_r;
        win_r[2] <= win_r[3];
        win_r[3] <= mid_rd_r;
        win_r[4] <= win_r[5];
        win_r[5] <= b_pix_r;
      end
    end
  end

  // line buffers: read on accept, write back in the next cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      top_rd_r <= upper_mem[col_r];
      mid_rd_r <= middle_mem[col_r];
      b_pix_r  <= in_pixel;
      b_idx_r  <= col_r;
    end
    if (b_valid_r) begin
      upper_mem[b_idx_r]  <= mid_rd_r;
      middle_mem[b_idx_r] <= b_pix_r;
    end
  end

  assign push = b_valid_r & b_emit_r;

  always_comb begin
    push_word.tl   = win_r[0];
    push_word.t    = win_r[1];
    push_word.tr   = top_rd_r;
    push_word.l    = win_r[2];
    push_word.ctr  = win_r[3];
    push_word.r    = mid_rd_r;
    push_word.bl   = win_r[4];
    push_word.b    = win_r[5];
    push_word.br   = b_pix_r;
    push_word.last = b_last_r;
  end

endmodule

@@ rtl/lbp_queue.sv @@
module lbp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lbp_pkg::lbp_win_t   push_word,
  input  logic                pop,
  output lbp_pkg::lbp_win_t   pop_word,
  output lbp_pkg::lbp_qstat_t stat
);

  lbp_pkg::lbp_win_t mem [lbp_pkg::Q_DEPTH];

  logic [lbp_pkg::Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [lbp_pkg::Q_LW-1:0] level_r, level_nxt;

  always_comb begin
    level_nxt = level_r;
    if (push && !pop) level_nxt = level_r + lbp_pkg::Q_LW'(1);
    if (pop && !push) level_nxt = level_r - lbp_pkg::Q_LW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      level_r <= level_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + lbp_pkg::Q_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + lbp_pkg::Q_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_word;
  end

  assign pop_word   = mem[rd_ptr_r];
  assign stat.level = level_r;
  assign stat.empty = (level_r == '0);

endmodule

@@ rtl/lbp_back.sv @@
module lbp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  lbp_pkg::lbp_qstat_t q_stat,
  input  lbp_pkg::lbp_win_t   q_word,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_code,
  output logic                out_last
);

  logic       valid_r;
  logic [7:0] code_r, code_nxt;
  logic       last_r;

  always_comb begin
    code_nxt[7] = q_word.tl > q_word.ctr;
    code_nxt[6] = q_word.t  > q_word.ctr;
    code_nxt[5] = q_word.tr > q_word.ctr;
    code_nxt[4] = q_word.r  > q_word.ctr;
    code_nxt[3] = q_word.br > q_word.ctr;
    code_nxt[2] = q_word.b  > q_word.ctr;
    code_nxt[1] = q_word.bl > q_word.ctr;
    code_nxt[0] = q_word.l  > q_word.ctr;
  end

  assign pop = !q_stat.empty && (!valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      code_r <= code_nxt;
      last_r <= q_word.last;
    end
  end

  assign out_valid = valid_r;
  assign out_code  = code_r;
  assign out_last  = last_r;

endmodule

@@ bench/testbench.sv @@
module testbench;

  localparam int unsigned LINE_DEPTH   = 1024;
  localparam int unsigned RANDOM_ITEMS = 1350;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned SETTLE       = 8;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } lbp_code_t;

  class lbp_scoreboard;
    logic [7:0]  upper_row [LINE_DEPTH];
    logic [7:0]  middle_row [LINE_DEPTH];
    logic [7:0]  win [6];
    int unsigned col;
    int unsigned row;
    logic [10:0] width_reg;
    logic [15:0] height_reg;
    lbp_code_t   codes_due [$];
    int          errors;

    function new();
      foreach (upper_row[i]) begin
        upper_row[i] = '0;
        middle_row[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      col = 0;
      row = 0;
      width_reg = lbp_pkg::WIDTH_RESET;
      height_reg = lbp_pkg::HEIGHT_RESET;
      errors = 0;
    endfunction

    task report(input string msg);
      if (errors < 40) $display("%0t: %s", $time, msg);
      errors++;
    endtask

    function void write_reg(input logic [2:0] addr, input logic [31:0] data);
      case (addr)
        lbp_pkg::REG_ADDR_WIDTH: width_reg = data[10:0];
        lbp_pkg::REG_ADDR_HEIGHT: height_reg = data[15:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(input logic [2:0] addr);
      case (addr)
        lbp_pkg::REG_ADDR_WIDTH: return {21'b0, width_reg};
        lbp_pkg::REG_ADDR_HEIGHT: return {16'b0, height_reg};
        default: return '0;
      endcase
    endfunction

    function int unsigned eff_width();
      if (width_reg < 3) return 3;
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      return (height_reg < 3) ? 3 : height_reg;
    endfunction

    function bit at_frame_start();
      return col == 0 && row == 0;
    endfunction

    // one accepted pixel word: predict its code, then shift window and lines
    function void note_pixel(input logic [7:0] p);
      int unsigned w, h, idx;
      logic [7:0]  top, mid, ctr;
      bit          row_end, frame_end;
      lbp_code_t   r;
      w = eff_width();
      h = eff_height();
      idx = (col < LINE_DEPTH) ? col : LINE_DEPTH - 1;
      top = upper_row[idx];
      mid = middle_row[idx];
      row_end = col >= w - 1;
      frame_end = row_end && row >= h - 1;
      if (row >= 2 && col >= 2) begin
        ctr = win[3];
        r.code = {win[0] > ctr, win[1] > ctr, top > ctr, mid > ctr,
                  p > ctr, win[5] > ctr, win[4] > ctr, win[2] > ctr};
        r.last = frame_end;
        codes_due.push_back(r);
      end
      win[0] = win[1];
      win[1] = top;
      win[2] = win[3];
      win[3] = mid;
      win[4] = win[5];
      win[5] = p;
      upper_row[idx] = mid;
      middle_row[idx] = p;
      if (row_end) begin
        col = 0;
        row = frame_end ? 0 : (row + 1) & 16'hFFFF;
      end else begin
        col = col + 1;
      end
    endfunction

    task check_code(input logic [7:0] code, input logic last);
      lbp_code_t e;
      if (codes_due.size() == 0) begin
        report($sformatf("unexpected code word %02h last %b", code, last));
      end else begin
        e = codes_due.pop_front();
        if (code !== e.code) report($sformatf("code %02h, predicted %02h", code, e.code));
        if (last !== e.last) report($sformatf("last %b, predicted %b", last, e.last));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;     // [7:0] pixel
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;    // [7:0] code
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  lbp_scoreboard sb = new();
  int unsigned   cycle_count = 0;
  int unsigned   pixels_sent = 0;
  bit            in_gaps = 1'b0;
  bit            out_gaps = 1'b0;
  int unsigned   pix_mode = 0;
  int unsigned   pix_base = 0;

  lbp_3x3_pattern_stream i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_code(out_tdata, out_tlast);
  end

  // code sink with random stalls
  initial begin
    int unsigned k;
    forever begin
      k = out_gaps ? $urandom_range(0, 15) : 0;
      if (k != 0) begin
        out_tready <= 1'b0;
        repeat (k) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  function automatic logic [7:0] next_pixel();
    case (pix_mode)
      1: return 8'(pix_base + $urandom_range(0, 3));
      2: begin
        case ($urandom_range(0, 2))
          0: return 8'h00;
          1: return 8'hFF;
          default: return 8'($urandom_range(0, 255));
        endcase
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixel(input logic [7:0] p);
    int unsigned g;
    g = in_gaps ? $urandom_range(0, 15) : 0;
    if (g != 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= p;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_pixel(p);
    pixels_sent++;
  endtask

  task automatic send_pixels(input int unsigned n);
    repeat (n) send_pixel(next_pixel());
  endtask

  task automatic finish_frame();
    do send_pixel(next_pixel()); while (!sb.at_frame_start());
  endtask

  // drop valid, let every predicted code arrive, then let the pipeline settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.codes_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic check_reg(input logic [2:0] addr);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== sb.reg_value(addr))
      sb.report($sformatf("register %0h reads %0h, predicted %0h",
                          addr, cfg_prdata, sb.reg_value(addr)));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.write_reg(addr, data);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    check_reg(addr);
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h);
    cfg_write(lbp_pkg::REG_ADDR_WIDTH, w);
    cfg_write(lbp_pkg::REG_ADDR_HEIGHT, h);
  endtask

  task automatic send_list(input logic [7:0] px [9]);
    foreach (px[i]) send_pixel(px[i]);
  endtask

  task automatic run_phase();
    int unsigned kind, r, w, h;
    kind = $urandom_range(0, 7);
    r = $urandom_range(0, 3);
    in_gaps = r[0];
    out_gaps = r[1];
    pix_mode = $urandom_range(0, 2);
    pix_base = $urandom_range(0, 252);
    r = $urandom_range(0, 9);
    if (r == 0) w = $urandom_range(0, 2);
    else if (r <= 6) w = $urandom_range(3, 10);
    else w = $urandom_range(11, 40);
    h = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
    set_frame(w, h);
    w = sb.eff_width();
    h = sb.eff_height();
    if (kind == 0) begin
      // tallest height, cut short mid-frame
      cfg_write(lbp_pkg::REG_ADDR_HEIGHT, 32'hFFFF);
      send_pixels(w * $urandom_range(3, 6) + $urandom_range(0, w - 1));
      wait_idle();
      cfg_write(lbp_pkg::REG_ADDR_HEIGHT, $urandom_range(0, sb.row));
      finish_frame();
    end else if (kind == 1) begin
      // mid-frame change: width only shrinks so every line entry read was written
      send_pixels(2 * w + $urandom_range(0, w * (h - 2) - 1));
      wait_idle();
      if ($urandom_range(0, 1) == 0) cfg_write(lbp_pkg::REG_ADDR_WIDTH, $urandom_range(0, w));
      else cfg_write(lbp_pkg::REG_ADDR_HEIGHT, $urandom_range(0, h + 3));
      finish_frame();
    end else begin
      repeat ($urandom_range(1, 3)) finish_frame();
    end
    wait_idle();
  endtask

  initial begin
    logic [7:0]  mixed [9];
    logic [7:0]  all_set [9];
    int unsigned start_count;
    mixed = '{8'd255, 8'd0, 8'd128, 8'd127, 8'd128, 8'd128, 8'd0, 8'd255, 8'd129};
    all_set = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd0, 8'd6, 8'd7, 8'd8, 8'd9};
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_reg(lbp_pkg::REG_ADDR_WIDTH);
    check_reg(lbp_pkg::REG_ADDR_HEIGHT);

    // smallest frames: mixed greater/equal/less, then clamped sizes with all bits set
    set_frame(3, 3);
    send_list(mixed);
    wait_idle();
    set_frame(1, 1);
    send_list(all_set);
    wait_idle();

    start_count = pixels_sent;
    while (pixels_sent - start_count < RANDOM_ITEMS) run_phase();

    // register extremes read back as written
    set_frame(2047, 0);
    repeat (20) @(posedge clk);

    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/lbp_pkg.sv
rtl/lbp_front.sv
rtl/lbp_queue.sv
rtl/lbp_back.sv
rtl/lbp_3x3_pattern_stream.sv
bench/testbench.sv
